// ===== src/group_bitmap_allocator_assert.svh =====
// Assertion macros for the group bitmap allocator.
// Included by the top level. The macros need clk and rst_n in scope.
`ifndef GROUP_BITMAP_ALLOCATOR_ASSERT_SVH
`define GROUP_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gba_pkg.sv =====
// Shared types and constants of the group bitmap allocator.
// No dependencies; the modules and the testbench import it, the interfaces refer to it by name.
`default_nettype none

package gba_pkg;

  localparam int WORD_BITS  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] BPG_RESET  = 16'd8192;
  localparam logic [6:0]  GIU_RESET  = 7'd1;
  localparam logic        BOFF_RESET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_GROUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET    = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOAD_WORD  = 2'd0,
    REQ_LOAD_COUNT = 2'd1,
    REQ_ALLOC      = 2'd2,
    REQ_LOAD_TOTAL = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_LOADED  = 2'd2
  } status_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic latch_req;
    logic do_load;
    logic scan_start;
    logic grp_next;
    logic word_start;
    logic word_next;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic req_alloc;
    logic scan_empty;
    logic grp_last;
    logic cnt_zero;
    logic word_free;
    logic word_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/gba_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
// Depends on gba_pkg for field widths.
`default_nettype none

interface gba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  group_sel;
  logic [9:0]  word_sel;
  logic [31:0] load_data;

  modport source (output valid, req_type, group_sel, word_sel, load_data, input ready);
  modport sink   (input valid, req_type, group_sel, word_sel, load_data, output ready);
endinterface

interface gba_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_number;
  logic [5:0]  dirty_group;
  logic [9:0]  dirty_word_index;
  logic [31:0] dirty_word;
  logic [31:0] total_free_left;

  modport source (output valid, status, alloc_number, dirty_group, dirty_word_index,
                  dirty_word, total_free_left, input ready);
  modport sink   (input valid, status, alloc_number, dirty_group, dirty_word_index,
                  dirty_word, total_free_left, output ready);
endinterface

interface gba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gba_pkg::CFG_IDX_W-1:0]    index;
  logic [gba_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/group_bitmap_allocator.sv =====
// First-fit allocator over per-group allocation bitmaps. Software fills the
// bitmap words, the per-group free counts and the total free count with load
// requests; an allocate request walks the groups in order, passes over any
// group whose free count is zero, scans the remaining groups' bitmap words
// from bit 0 upward, sets the first clear bit and answers with
// group * bits_per_group + bit + base_offset together with the updated word,
// so that the word can be written back to disk. Every request returns exactly
// one result. A load request is carried out in the dispatch state, where its
// result is registered. An allocate request visits groups and their words in
// turn; each group visit costs one registered read of the free-count memory
// and each word one registered read of the bitmap memory, and these reads set
// the scan rate. Either result then moves into the output register once that
// register is free. A new request is accepted once the previous one has moved
// into the output register, even if that result is still waiting
// to be taken. The free counts carry a valid bit per group that reset clears,
// so no clearing pass is needed; bitmap words that were never loaded read as
// unknown. Configuration writes are always accepted and must be issued only
// while no request is in flight.
//
// Top level of the group bitmap allocator.
// Depends on gba_pkg, the channel interfaces, gba_ctrl and gba_dp.
`default_nettype none

`include "group_bitmap_allocator_assert.svh"

module group_bitmap_allocator #(
  parameter int MAX_GROUPS         = 64,
  parameter int MAX_BITS_PER_GROUP = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  gba_req_if.sink   in_req,
  gba_res_if.source out_res,
  gba_cfg_if.sink   cfg_wr
);
  import gba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Register writes never stall.
  assign cfg_wr.ready = 1'b1;

  // The sequencer owns both handshakes and steps the datapath through the scan.
  gba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds all storage and drives the result payload directly.
  gba_dp #(
    .MAX_GROUPS         (MAX_GROUPS),
    .MAX_BITS_PER_GROUP (MAX_BITS_PER_GROUP)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_wr.valid),
    .cfg_index            (cfg_wr.index),
    .cfg_data             (cfg_wr.data),
    .in_req_type          (in_req.req_type),
    .in_group_sel         (in_req.group_sel),
    .in_word_sel          (in_req.word_sel),
    .in_load_data         (in_req.load_data),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_status           (out_res.status),
    .out_alloc_number     (out_res.alloc_number),
    .out_dirty_group      (out_res.dirty_group),
    .out_dirty_word_index (out_res.dirty_word_index),
    .out_dirty_word       (out_res.dirty_word),
    .out_total_free_left  (out_res.total_free_left)
  );

  // Only one request is worked on at a time.
  `GBA_ASSERT_NEXT(a_one_request, in_req.valid && in_req.ready, !in_req.ready, "request accepted while busy")
  // A finished result never overwrites one that is still waiting.
  `GBA_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_res.valid || out_res.ready, "pending result overwritten")
  // A bit is committed only when the scanned word has a free bit in range.
  `GBA_ASSERT_IMPL(a_commit_free, cmd.commit, stat.word_free && !stat.cnt_zero, "commit without a free bit")
  // In the cycle after a result is registered, the next request can be taken and the result is valid.
  `GBA_ASSERT_NEXT(a_load_then_ready, cmd.out_load, in_req.ready && out_res.valid, "result load out of step")

endmodule

`default_nettype wire

// ===== src/gba_ctrl.sv =====
// Sequencer of the group bitmap allocator: request handshake and scan control.
// Depends on gba_pkg for the command and status structs.
`default_nettype none

module gba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gba_pkg::dp_stat_t stat,
  output gba_pkg::dp_cmd_t  cmd
);
  import gba_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_GRP   = 7'b0000100,
    S_GTEST = 7'b0001000,
    S_WRD   = 7'b0010000,
    S_WTEST = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.req_alloc) begin
          cmd.scan_start = 1'b1;
          state_nxt      = stat.scan_empty ? S_DONE : S_GRP;
        end else begin
          cmd.do_load = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_GRP: begin
        state_nxt = S_GTEST;
      end
      S_GTEST: begin
        if (!stat.cnt_zero) begin
          cmd.word_start = 1'b1;
          state_nxt      = S_WRD;
        end else if (stat.grp_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.grp_next = 1'b1;
          state_nxt    = S_GRP;
        end
      end
      S_WRD: begin
        state_nxt = S_WTEST;
      end
      S_WTEST: begin
        if (stat.word_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else if (!stat.word_last) begin
          cmd.word_next = 1'b1;
          state_nxt     = S_WRD;
        end else if (stat.grp_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.grp_next = 1'b1;
          state_nxt    = S_GRP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/gba_dp.sv =====
// Datapath of the group bitmap allocator: configuration, bitmap and count
// memories, scan counters and result registers. Depends on gba_pkg.
`default_nettype none

module gba_dp #(
  parameter int MAX_GROUPS         = 64,
  parameter int MAX_BITS_PER_GROUP = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                     in_req_type,
  input  logic [5:0]                     in_group_sel,
  input  logic [9:0]                     in_word_sel,
  input  logic [31:0]                    in_load_data,
  input  gba_pkg::dp_cmd_t               cmd,
  output gba_pkg::dp_stat_t              stat,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_alloc_number,
  output logic [5:0]                     out_dirty_group,
  output logic [9:0]                     out_dirty_word_index,
  output logic [31:0]                    out_dirty_word,
  output logic [31:0]                    out_total_free_left
);
  import gba_pkg::*;

  localparam int WPG   = MAX_BITS_PER_GROUP / WORD_BITS;
  localparam int DEPTH = MAX_GROUPS * WPG;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WIW   = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int CAP   = WPG * WORD_BITS;

  // Configuration registers.
  logic [15:0] bpg_r;
  logic [6:0]  giu_r;
  logic        boff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpg_r  <= BPG_RESET;
      giu_r  <= GIU_RESET;
      boff_r <= BOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BITS_PER_GROUP: bpg_r  <= cfg_data;
        CFG_GROUPS_IN_USE:  giu_r  <= cfg_data[6:0];
        CFG_BASE_OFFSET:    boff_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective scan limits.
  logic [15:0] limit;
  logic [8:0]  giu9;
  logic [8:0]  ngroups;

  assign limit   = (bpg_r > 16'(CAP)) ? 16'(CAP) : bpg_r;
  assign giu9    = 9'(giu_r);
  assign ngroups = (giu9 > 9'(MAX_GROUPS)) ? 9'(MAX_GROUPS) : giu9;

  // Request held for the duration of its processing.
  req_type_t   req_r;
  logic [5:0]  gsel_r;
  logic [9:0]  wsel_r;
  logic [31:0] data_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r  <= req_type_t'(in_req_type);
      gsel_r <= in_group_sel;
      wsel_r <= in_word_sel;
      data_r <= in_load_data;
    end
  end

  logic gsel_ok, wsel_ok;
  logic [AW-1:0] load_addr;

  assign gsel_ok   = 9'(gsel_r) < 9'(MAX_GROUPS);
  assign wsel_ok   = 11'(wsel_r) < 11'(WPG);
  assign load_addr = AW'(int'(gsel_r) * WPG + int'(wsel_r));

  // Scan position: group, word within group, and bits left in the group.
  logic [GIW-1:0] g_r;
  logic [AW-1:0]  grp_addr_r;
  logic [WIW-1:0] w_r;
  logic [15:0]    rem_r;
  logic [31:0]    base_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      g_r        <= '0;
      grp_addr_r <= '0;
      base_r     <= '0;
    end else if (cmd.grp_next) begin
      g_r        <= g_r + GIW'(1);
      grp_addr_r <= grp_addr_r + AW'(WPG);
      base_r     <= base_r + 32'(bpg_r);
    end
    if (cmd.word_start) begin
      w_r   <= '0;
      rem_r <= limit;
    end else if (cmd.word_next) begin
      w_r   <= w_r + WIW'(1);
      rem_r <= rem_r - 16'(WORD_BITS);
    end
  end

  // Bitmap memory, one write port and one registered read port.
  logic [31:0]   bmem [DEPTH];
  logic [31:0]   word_q;
  logic [AW-1:0] word_addr;
  logic          bm_we;
  logic [AW-1:0] bm_waddr;
  logic [31:0]   bm_wdata;

  logic [31:0] mask;
  logic [31:0] freebits;
  logic [4:0]  bit_idx;
  logic [31:0] new_word;

  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  n;
    x = v;
    n = '0;
    if (x[15:0] == 16'd0) begin n[4] = 1'b1; x = x >> 16; end
    if (x[7:0] == 8'd0)   begin n[3] = 1'b1; x = x >> 8;  end
    if (x[3:0] == 4'd0)   begin n[2] = 1'b1; x = x >> 4;  end
    if (x[1:0] == 2'd0)   begin n[1] = 1'b1; x = x >> 2;  end
    if (x[0] == 1'b0)     begin n[0] = 1'b1; end
    return n;
  endfunction

  assign word_addr = grp_addr_r + AW'(w_r);
  assign mask      = (rem_r >= 16'(WORD_BITS)) ? '1 : ((32'd1 << rem_r[4:0]) - 32'd1);
  assign freebits  = ~word_q & mask;
  assign bit_idx   = lowest_set(freebits);
  assign new_word  = word_q | (32'd1 << bit_idx);

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = word_addr;
    bm_wdata = new_word;
    if (cmd.commit) begin
      bm_we = 1'b1;
    end else if (cmd.do_load && (req_r == REQ_LOAD_WORD) && gsel_ok && wsel_ok) begin
      bm_we    = 1'b1;
      bm_waddr = load_addr;
      bm_wdata = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bmem[bm_waddr] <= bm_wdata;
    end
    word_q <= bmem[word_addr];
  end

  // Group free counts: memory with one valid bit per entry, cleared by reset.
  logic [15:0]           cmem [MAX_GROUPS];
  logic [MAX_GROUPS-1:0] cval_r;
  logic [15:0]           cnt_q;
  logic                  cntv_q;
  logic                  cm_we;
  logic [GIW-1:0]        cm_waddr;
  logic [15:0]           cm_wdata;

  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = g_r;
    cm_wdata = cnt_q - 16'd1;
    if (cmd.commit) begin
      cm_we = 1'b1;
    end else if (cmd.do_load && (req_r == REQ_LOAD_COUNT) && gsel_ok) begin
      cm_we    = 1'b1;
      cm_waddr = GIW'(gsel_r);
      cm_wdata = data_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    cnt_q  <= cmem[g_r];
    cntv_q <= cval_r[g_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cval_r <= '0;
    end else if (cm_we) begin
      cval_r[cm_waddr] <= 1'b1;
    end
  end

  // Total free count, saturating at zero on allocation.
  logic [31:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.commit) begin
      if (total_r != 32'd0) begin
        total_r <= total_r - 32'd1;
      end
    end else if (cmd.do_load && (req_r == REQ_LOAD_TOTAL)) begin
      total_r <= data_r;
    end
  end

  // Result of the request in progress, then the output register.
  status_t     res_status_r;
  logic [31:0] res_num_r;
  logic [5:0]  res_grp_r;
  logic [9:0]  res_idx_r;
  logic [31:0] res_word_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= ST_ALLOC;
      res_num_r    <= base_r + 32'({w_r, 5'b0}) + 32'(bit_idx) + 32'(boff_r);
      res_grp_r    <= 6'(g_r);
      res_idx_r    <= 10'(w_r);
      res_word_r   <= new_word;
    end else if (cmd.scan_start || cmd.do_load) begin
      res_status_r <= cmd.do_load ? ST_LOADED : ST_NOSPACE;
      res_num_r    <= '0;
      res_grp_r    <= '0;
      res_idx_r    <= '0;
      res_word_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status           <= res_status_r;
      out_alloc_number     <= res_num_r;
      out_dirty_group      <= res_grp_r;
      out_dirty_word_index <= res_idx_r;
      out_dirty_word       <= res_word_r;
      out_total_free_left  <= total_r;
    end
  end

  assign stat.req_alloc  = (req_r == REQ_ALLOC);
  assign stat.scan_empty = (ngroups == 9'd0) || (limit == 16'd0);
  assign stat.grp_last   = (9'(g_r) + 9'd1) >= ngroups;
  assign stat.cnt_zero   = !cntv_q || (cnt_q == 16'd0);
  assign stat.word_free  = |freebits;
  assign stat.word_last  = rem_r <= 16'(WORD_BITS);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the group bitmap allocator: a table of directed
// requests, then randomized phases, each result compared with a shadow model or a typed result.
// Depends on gba_pkg, the channel interfaces in gba_if.sv and the RTL top level.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gba_pkg::*;

  // Geometry of the instance under test (default parameters of the block).
  localparam int N_GROUPS      = 64;
  localparam int BITS_CAP      = 8192;
  localparam int WORDS_PER_GRP = BITS_CAP / WORD_BITS;
  localparam int STORE_WORDS   = N_GROUPS * WORDS_PER_GRP;

  // Index 3 of the configuration port names no register; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // The watchdog fires after this many cycles in which no channel moves
  // anything. The slowest legal request scans 64 groups of 256 words, and the
  // receiver may add a long hold-off on top of that.
  localparam int QUIET_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 50;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    req_type_t   kind;
    logic [5:0]  grp;
    logic [9:0]  widx;
    logic [31:0] data;
  } alloc_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] number;
    logic [5:0]  dgroup;
    logic [9:0]  dindex;
    logic [31:0] dword;
    logic [31:0] total;
  } alloc_res_t;

  // One line of the directed table: either a register write or a request,
  // the latter optionally with a result typed in by hand.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cidx;
    logic [15:0]          cdata;
    alloc_req_t           req;
    bit                   typed;
    alloc_res_t           want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gba_req_if req_ch ();
  gba_res_if res_ch ();
  gba_cfg_if cfg_ch ();

  group_bitmap_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch),
    .cfg_wr  (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator state. shadow_loaded tracks which bitmap
  // words have been written, because the block leaves the rest undefined and
  // an allocation must never be allowed to read one of them.
  logic [31:0] shadow_bitmap [0:STORE_WORDS-1];
  bit          shadow_loaded [0:STORE_WORDS-1];
  logic [15:0] shadow_count  [0:N_GROUPS-1];
  logic [31:0] shadow_total;
  logic [15:0] cur_bpg;
  logic [6:0]  cur_giu;
  logic        cur_boff;

  alloc_res_t  pending_results [$];
  alloc_res_t  head_res;
  alloc_res_t  blank_res;
  plan_row_t   plan [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  burst_left     = 0;
  bit  hold_off_req   = 1'b0;

  // ---------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------

  // Groups actually scanned: the register value clamped to the store size.
  function automatic int scan_groups();
    return (int'(cur_giu) > N_GROUPS) ? N_GROUPS : int'(cur_giu);
  endfunction

  // Bits actually scanned per group; numbering still uses the raw register.
  function automatic int scan_bits();
    return (int'(cur_bpg) > BITS_CAP) ? BITS_CAP : int'(cur_bpg);
  endfunction

  // Walks the scan an allocation would make right now and reports the first
  // bitmap word it would read before ever finding a free bit, if that word
  // was never loaded.
  function automatic bit find_unloaded(output int idx);
    int          ng;
    int          lim;
    int          rem;
    logic [31:0] mask;
    ng  = scan_groups();
    lim = scan_bits();
    idx = 0;
    for (int g = 0; g < ng; g++) begin
      if (shadow_count[g] != 16'd0) begin
        for (int w = 0; w * 32 < lim; w++) begin
          idx  = g * WORDS_PER_GRP + w;
          if (!shadow_loaded[idx]) return 1'b1;
          rem  = lim - w * 32;
          mask = (rem >= 32) ? 32'hFFFF_FFFF : ((32'h1 << rem) - 32'h1);
          if ((~shadow_bitmap[idx] & mask) != 32'h0) return 1'b0;
        end
      end
    end
    return 1'b0;
  endfunction

  // Applies one accepted request to the shadow state and returns the
  // result the block has to produce for it.
  function automatic alloc_res_t apply_request(alloc_req_t r);
    alloc_res_t  res;
    int          ng;
    int          lim;
    int          idx;
    int          rem;
    int          b;
    logic [31:0] mask;
    logic [31:0] freebits;
    bit          found;
    res        = '0;
    res.status = ST_LOADED;
    case (r.kind)
      REQ_LOAD_WORD: begin
        // Word indexes past the end of a group are answered but dropped.
        if (int'(r.widx) < WORDS_PER_GRP) begin
          idx = int'(r.grp) * WORDS_PER_GRP + int'(r.widx);
          shadow_bitmap[idx] = r.data;
          shadow_loaded[idx] = 1'b1;
        end
      end
      REQ_LOAD_COUNT: shadow_count[r.grp] = r.data[15:0];
      REQ_LOAD_TOTAL: shadow_total = r.data;
      default: begin
        ng         = scan_groups();
        lim        = scan_bits();
        found      = 1'b0;
        res.status = ST_NOSPACE;
        for (int g = 0; g < ng && !found; g++) begin
          if (shadow_count[g] != 16'd0) begin
            for (int w = 0; w * 32 < lim && !found; w++) begin
              idx      = g * WORDS_PER_GRP + w;
              rem      = lim - w * 32;
              mask     = (rem >= 32) ? 32'hFFFF_FFFF : ((32'h1 << rem) - 32'h1);
              freebits = ~shadow_bitmap[idx] & mask;
              if (freebits != 32'h0) begin
                b = 0;
                while (!freebits[b]) b++;
                shadow_bitmap[idx] = shadow_bitmap[idx] | (32'h1 << b);
                shadow_count[g]    = shadow_count[g] - 16'd1;
                // The total saturates at zero.
                if (shadow_total != 32'h0) shadow_total = shadow_total - 32'h1;
                res.status = ST_ALLOC;
                res.number = 32'(g) * 32'(cur_bpg) + 32'(w * 32) + 32'(b)
                             + 32'(cur_boff);
                res.dgroup = 6'(g);
                res.dindex = 10'(w);
                res.dword  = shadow_bitmap[idx];
                found      = 1'b1;
              end
            end
          end
        end
      end
    endcase
    res.total = shadow_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  // Every mismatch goes through here; printing stops after a while so that
  // a badly broken block cannot flood the log, but counting goes on.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Each result taken by the receiver is matched against the oldest
  // outstanding request, field by field.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", res_ch.alloc_number, 32'h0);
      end else begin
        head_res = pending_results.pop_front();
        if (res_ch.status !== head_res.status)
          report_mismatch("status", 32'(res_ch.status), 32'(head_res.status));
        if (res_ch.alloc_number !== head_res.number)
          report_mismatch("alloc_number", res_ch.alloc_number, head_res.number);
        if (res_ch.dirty_group !== head_res.dgroup)
          report_mismatch("dirty_group", 32'(res_ch.dirty_group), 32'(head_res.dgroup));
        if (res_ch.dirty_word_index !== head_res.dindex)
          report_mismatch("dirty_word_index", 32'(res_ch.dirty_word_index),
                          32'(head_res.dindex));
        if (res_ch.dirty_word !== head_res.dword)
          report_mismatch("dirty_word", res_ch.dirty_word, head_res.dword);
        if (res_ch.total_free_left !== head_res.total)
          report_mismatch("total_free_left", res_ch.total_free_left, head_res.total);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stalls on one of four randomly chosen ready patterns, and
  // on demand holds ready low for a long stretch so that the block backs up
  // into its request channel.
  // ---------------------------------------------------------------------
  initial begin
    int         mode;
    int         span;
    logic [7:0] rdy_pattern;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode        = $urandom_range(0, 3);
      span        = $urandom_range(20, 200);
      rdy_pattern = 8'($urandom);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          res_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0:       res_ch.ready = 1'b1;
          1:       res_ch.ready = 1'($urandom_range(0, 1));
          2:       res_ch.ready = ($urandom_range(0, 3) == 0);
          default: res_ch.ready = rdy_pattern[k % 8];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Bitmap words with a spread of occupancy: full, random, one hole, empty.
  function automatic logic [31:0] random_bitmap_word();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'($urandom);
      2:       return ~(32'h1 << $urandom_range(0, 31));
      default: return 32'h0;
    endcase
  endfunction

  // Offers one request and waits for the block to take it. The sender works
  // in bursts; between bursts valid drops and the payload wanders so that
  // the block is seen to ignore it. The expected result is queued at the
  // edge where the request is accepted.
  task automatic drive_item(alloc_req_t r, bit typed, alloc_res_t want);
    alloc_res_t got;
    int         gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid     = 1'b0;
        req_ch.req_type  = 2'($urandom);
        req_ch.group_sel = 6'($urandom);
        req_ch.word_sel  = 10'($urandom);
        req_ch.load_data = 32'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.req_type  = r.kind;
    req_ch.group_sel = r.grp;
    req_ch.word_sel  = r.widx;
    req_ch.load_data = r.data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    got = apply_request(r);
    pending_results.push_back(typed ? want : got);
  endtask

  // Before an allocate request goes out, every bitmap word its scan would
  // touch is loaded first, so the block never reads an unwritten word.
  task automatic send_request(alloc_req_t r, bit typed, alloc_res_t want);
    alloc_req_t fill;
    int         idx;
    if (r.kind == REQ_ALLOC) begin
      while (find_unloaded(idx)) begin
        fill.kind = REQ_LOAD_WORD;
        fill.grp  = 6'(idx / WORDS_PER_GRP);
        fill.widx = 10'(idx % WORDS_PER_GRP);
        fill.data = random_bitmap_word();
        drive_item(fill, 1'b0, blank_res);
      end
    end
    drive_item(r, typed, want);
  endtask

  // Drops valid and waits until every outstanding request has been answered.
  // Since every request yields a result, the block is idle afterwards.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One configuration write; the shadow copy follows at the accepting edge.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_BITS_PER_GROUP: cur_bpg  = data;
      CFG_GROUPS_IN_USE:  cur_giu  = data[6:0];
      CFG_BASE_OFFSET:    cur_boff = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IDX_W'($urandom);
    cfg_ch.data  = 16'($urandom);
  endtask

  // ---------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------
  function automatic void row_req(req_type_t k, logic [5:0] g, logic [9:0] w,
                                  logic [31:0] d, bit typed = 1'b0,
                                  status_t st = ST_LOADED, logic [31:0] num = 32'h0,
                                  logic [5:0] dg = 6'h0, logic [9:0] di = 10'h0,
                                  logic [31:0] dw = 32'h0, logic [31:0] tot = 32'h0);
    plan_row_t row;
    row.is_cfg      = 1'b0;
    row.cidx        = '0;
    row.cdata       = '0;
    row.req.kind    = k;
    row.req.grp     = g;
    row.req.widx    = w;
    row.req.data    = d;
    row.typed       = typed;
    row.want.status = st;
    row.want.number = num;
    row.want.dgroup = dg;
    row.want.dindex = di;
    row.want.dword  = dw;
    row.want.total  = tot;
    plan.push_back(row);
  endfunction

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.cidx   = idx;
    row.cdata  = data;
    row.req    = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // Random phase: mostly allocations interleaved with refills of counts and
  // bitmap words aimed at the groups being scanned, plus a little noise
  // aimed anywhere. Optionally asks the receiver for a long hold-off and
  // pauses the sender until the block has drained.
  // ---------------------------------------------------------------------
  task automatic run_phase(int items, bit do_hold, bit do_pause);
    alloc_req_t r;
    int         pick;
    int         ng;
    int         nw;
    for (int i = 0; i < items; i++) begin
      ng     = (scan_groups() < 1) ? 1 : scan_groups();
      nw     = (scan_bits() + 31) / 32;
      nw     = (nw < 1) ? WORDS_PER_GRP : nw;
      pick   = $urandom_range(0, 99);
      r.grp  = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, ng - 1)) : 6'($urandom);
      r.widx = 10'($urandom);
      r.data = 32'($urandom);
      if (pick < 50) begin
        r.kind = REQ_ALLOC;
      end else if (pick < 68) begin
        r.kind = REQ_LOAD_COUNT;
        case ($urandom_range(0, 9))
          0, 1:    r.data = 32'h0;
          2:       r.data = 32'($urandom);
          default: r.data = ($urandom_range(0, 1) ? {16'($urandom), 16'h0} : 32'h0)
                            | 32'($urandom_range(1, 4));
        endcase
      end else if (pick < 90) begin
        r.kind = REQ_LOAD_WORD;
        if ($urandom_range(0, 6) != 0) r.widx = 10'($urandom_range(0, nw - 1));
        r.data = random_bitmap_word();
      end else begin
        r.kind = REQ_LOAD_TOTAL;
        case ($urandom_range(0, 4))
          0, 1:    r.data = 32'($urandom_range(0, 3));
          2:       r.data = 32'hFFFF_FFFF;
          default: r.data = 32'($urandom);
        endcase
      end
      if (do_hold && i == items / 3) hold_off_req = 1'b1;
      if (do_pause && i == (2 * items) / 3) wait_drained();
      send_request(r, 1'b0, blank_res);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] phase_bpg  [11];
    logic [6:0]  phase_giu  [11];
    logic        phase_boff [11];
    int          phase_len  [11];
    bit          hold_phase [11];
    bit          pause_phase[11];

    // Everything the block sees is known from time zero.
    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_LOAD_WORD;
    req_ch.group_sel = '0;
    req_ch.word_sel  = '0;
    req_ch.load_data = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_BITS_PER_GROUP;
    cfg_ch.data      = '0;
    blank_res        = '0;

    // Shadow state after reset.
    for (int i = 0; i < STORE_WORDS; i++) begin
      shadow_bitmap[i] = 32'h0;
      shadow_loaded[i] = 1'b0;
    end
    for (int g = 0; g < N_GROUPS; g++) shadow_count[g] = 16'h0;
    shadow_total = 32'h0;
    cur_bpg      = BPG_RESET;
    cur_giu      = GIU_RESET;
    cur_boff     = BOFF_RESET;

    // Directed part, starting from the reset configuration (8192 bits per
    // group, one group, offset one). Typed rows are the ones whose answer
    // is obvious: the empty allocator, plain loads and the very first
    // allocation.
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0, 1'b1, ST_NOSPACE);
    row_req(REQ_LOAD_TOTAL, 6'h3F, 10'h3FF, 32'hFFFF_FFFF, 1'b1, ST_LOADED,
            32'h0, 6'h0, 10'h0, 32'h0, 32'hFFFF_FFFF);
    // Word index far past the end of a group, and just past it: dropped.
    row_req(REQ_LOAD_WORD, 6'h3F, 10'h3FF, 32'h0, 1'b1, ST_LOADED,
            32'h0, 6'h0, 10'h0, 32'h0, 32'hFFFF_FFFF);
    row_req(REQ_LOAD_WORD, 6'h0, 10'd256, 32'h0, 1'b1, ST_LOADED,
            32'h0, 6'h0, 10'h0, 32'h0, 32'hFFFF_FFFF);
    // The count keeps only its low 16 bits.
    row_req(REQ_LOAD_COUNT, 6'h0, 10'h0, 32'hABCD_0002, 1'b1, ST_LOADED,
            32'h0, 6'h0, 10'h0, 32'h0, 32'hFFFF_FFFF);
    row_req(REQ_LOAD_WORD, 6'h0, 10'h0, 32'hFFFF_FFFE, 1'b1, ST_LOADED,
            32'h0, 6'h0, 10'h0, 32'h0, 32'hFFFF_FFFF);
    row_req(REQ_ALLOC, 6'h3F, 10'h3FF, 32'hFFFF_FFFF, 1'b1, ST_ALLOC,
            32'd1, 6'h0, 10'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    row_req(REQ_LOAD_WORD, 6'h0, 10'h1, 32'h7FFF_FFFF);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    // Count of group 0 is now zero, so the group is skipped.
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    row_req(REQ_LOAD_TOTAL, 6'h0, 10'h0, 32'h0);
    row_req(REQ_LOAD_COUNT, 6'h0, 10'h0, 32'h0001_0000);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    row_req(REQ_LOAD_COUNT, 6'h0, 10'h0, 32'h0000_FFFF);
    row_req(REQ_LOAD_WORD, 6'h0, 10'h2, 32'h0);
    // Succeeds with the total already at zero: the total must not wrap.
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    // Five bits per group, two groups, no offset. Group 1 has bits 0..4
    // taken and only bits past the scan limit clear, and group 0 is full
    // while its count says otherwise: both are passed over.
    row_cfg(CFG_BITS_PER_GROUP, 16'd5);
    row_cfg(CFG_GROUPS_IN_USE, 16'd2);
    row_cfg(CFG_BASE_OFFSET, 16'd0);
    row_req(REQ_LOAD_COUNT, 6'h1, 10'h0, 32'h1);
    row_req(REQ_LOAD_WORD, 6'h1, 10'h0, 32'h0000_001F);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    row_req(REQ_LOAD_WORD, 6'h1, 10'h0, 32'h0000_000F);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    // Zero groups in use (upper bits of the write are ignored).
    row_cfg(CFG_GROUPS_IN_USE, 16'h0080);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    // Too many groups together with zero bits per group.
    row_cfg(CFG_GROUPS_IN_USE, 16'h007F);
    row_cfg(CFG_BITS_PER_GROUP, 16'd0);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);
    // More bits than a group can hold: the scan is capped, numbering is not.
    row_cfg(CFG_BITS_PER_GROUP, 16'h8000);
    row_cfg(CFG_GROUPS_IN_USE, 16'd2);
    row_cfg(CFG_BASE_OFFSET, 16'd1);
    row_req(REQ_LOAD_COUNT, 6'h0, 10'h0, 32'h0);
    row_req(REQ_ALLOC, 6'h0, 10'h0, 32'h0);

    // Random phases: bits per group, groups in use, base offset, length.
    // Most use small groups; the large ones get few requests.
    phase_bpg  = '{16'd1, 16'd5, 16'd32, 16'd33, 16'd100, 16'd17, 16'd8192,
                   16'd32768, 16'd0, 16'd64, 16'd3};
    phase_giu  = '{7'd1, 7'd3, 7'd8, 7'd64, 7'd16, 7'd127, 7'd2, 7'd4, 7'd10, 7'd0, 7'd64};
    phase_boff = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_len  = '{100, 120, 120, 120, 100, 120, 40, 40, 20, 20, 100};
    hold_phase = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    pause_phase = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_register(plan[i].cidx, plan[i].cdata);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < 11; p++) begin
      wait_drained();
      write_register(CFG_BITS_PER_GROUP, phase_bpg[p]);
      write_register(CFG_GROUPS_IN_USE, {9'($urandom), phase_giu[p]});
      write_register(CFG_BASE_OFFSET, {15'($urandom), phase_boff[p]});
      if (p == 0) write_register(CFG_SPARE_IDX, 16'($urandom));
      run_phase(phase_len[p], hold_phase[p], pause_phase[p]);
    end

    // Let the last results come home, then watch a little longer for any
    // stray result.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("requests left unanswered", 32'(pending_results.size()), 32'h0);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== group_bitmap_allocator.f =====
+incdir+src
src/gba_pkg.sv
src/gba_if.sv
src/gba_ctrl.sv
src/gba_dp.sv
src/group_bitmap_allocator.sv
tb/testbench.sv
